// ===== hw/rtl/rgb2rgba16_pkg.sv =====
// shared types, register indexes, constants and a helper function for the rgb to rgba16 converter
// no dependencies
package rgb2rgba16_pkg;

    typedef struct packed {
        logic [15:0] sample_red;
        logic [15:0] sample_green;
        logic [15:0] sample_blue;
        logic [15:0] sample_alpha;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic [15:0] out_alpha;
    } t_out_beat;

    // stage load enables for one lane
    typedef struct packed {
        logic en_mul;
        logic en_clip;
    } t_lane_ctl;

    // stage load enables for one range expander
    typedef struct packed {
        logic en_e1;
        logic en_e2;
        logic en_e3;
    } t_exp_ctl;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT_FLAGS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_RED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_GREEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_BLUE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ALPHA   = 3'd6;

    localparam logic [15:0] FULL_MAX = 16'hffff;
    localparam logic [15:0] LIM_LOW  = 16'd4096;
    localparam logic [15:0] LIM_HIGH = 16'd60160;

    // left shift 16 - depth, depth clamped to 8..16
    function automatic logic [3:0] depth_shift(input logic [4:0] bits);
        logic [4:0] d;
        begin
            if (bits < 5'd8) begin
                d = 5'd8;
            end else if (bits > 5'd16) begin
                d = 5'd16;
            end else begin
                d = bits;
            end
            depth_shift = 4'(5'd16 - d);
        end
    endfunction

endpackage

// ===== hw/rtl/rgb2rgba16_lane.sv =====
// one component lane: byte swap, gain multiply, depth shift, clip, invert
// depends on rgb2rgba16_pkg
module rgb2rgba16_lane (
    input  logic                         i_clk,
    input  rgb2rgba16_pkg::t_lane_ctl    i_ctl,
    input  logic [15:0]                  i_sample,
    input  logic                         i_swap,
    input  logic [7:0]                   i_gain,
    input  logic [3:0]                   i_shift,
    input  logic                         i_invert,
    output logic [15:0]                  o_value
);

    logic [23:0] r_prod;
    logic [15:0] r_value;
    logic [15:0] swapped;
    logic [31:0] shifted;
    logic [15:0] clipped;

    assign swapped = i_swap ? {i_sample[7:0], i_sample[15:8]} : i_sample;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_prod <= swapped * i_gain;
        end
    end

    always_comb begin
        shifted = {8'd0, r_prod} << i_shift;
        clipped = (|shifted[31:16]) ? rgb2rgba16_pkg::FULL_MAX : shifted[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_clip) begin
            r_value <= i_invert ? ~clipped : clipped;
        end
    end

    assign o_value = r_value;

endmodule

// ===== hw/rtl/rgb2rgba16_expand.sv =====
// limited to full range expansion, floor((v-4096)*65535/56064) by reciprocal multiply
// depends on rgb2rgba16_pkg
module rgb2rgba16_expand (
    input  logic                       i_clk,
    input  rgb2rgba16_pkg::t_exp_ctl   i_ctl,
    input  logic                       i_limited,
    input  logic [15:0]                i_value,
    output logic [15:0]                o_value
);

    localparam logic [1:0] SEL_PASS = 2'd0;
    localparam logic [1:0] SEL_ZERO = 2'd1;
    localparam logic [1:0] SEL_FULL = 2'd2;
    localparam logic [1:0] SEL_DIV  = 2'd3;

    // 56064 = 256 * 219, reciprocal of 219 scaled by 2^32
    localparam logic [24:0] RECIP   = 25'd19611722;
    localparam logic [7:0]  DIVISOR = 8'd219;

    logic [1:0]  r_sel1, r_sel2;
    logic [23:0] r_y1, r_y2;
    logic [15:0] r_v1, r_v2;
    logic [15:0] r_q;
    logic [15:0] r_out;

    logic [1:0]  n_sel;
    logic [15:0] x;
    logic [31:0] scaled;
    logic [48:0] prod;
    logic [23:0] rem;
    logic [15:0] q_fix;

    always_comb begin
        x      = i_value - rgb2rgba16_pkg::LIM_LOW;
        scaled = {x, 16'd0} - {16'd0, x};
        if (!i_limited) begin
            n_sel = SEL_PASS;
        end else if (i_value <= rgb2rgba16_pkg::LIM_LOW) begin
            n_sel = SEL_ZERO;
        end else if (i_value >= rgb2rgba16_pkg::LIM_HIGH) begin
            n_sel = SEL_FULL;
        end else begin
            n_sel = SEL_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_e1) begin
            r_sel1 <= n_sel;
            r_y1   <= scaled[31:8];
            r_v1   <= i_value;
        end
    end

    assign prod = r_y1 * RECIP;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_e2) begin
            r_sel2 <= r_sel1;
            r_y2   <= r_y1;
            r_v2   <= r_v1;
            r_q    <= prod[47:32];
        end
    end

    // estimate is exact or one low
    always_comb begin
        rem   = r_y2 - 24'(r_q) * 24'(DIVISOR);
        q_fix = (rem >= 24'(DIVISOR)) ? r_q + 16'd1 : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_e3) begin
            case (r_sel2)
                SEL_PASS: r_out <= r_v2;
                SEL_ZERO: r_out <= 16'd0;
                SEL_FULL: r_out <= rgb2rgba16_pkg::FULL_MAX;
                SEL_DIV:  r_out <= q_fix;
                default:  r_out <= r_v2;
            endcase
        end
    end

    assign o_value = r_out;

endmodule

// ===== hw/rtl/rgb_to_rgba16_converter.sv =====
// rgb_to_rgba16_converter: raw rgba pixel to 16-bit-per-channel rgba
// one pixel per cycle sustained while the output is not stalled
// stages: multiply, shift/clip/invert, then three range expansion stages
// each stage holds or advances on its own, so bubbles collapse under output stall
// reset (i_rst_n low, synchronous) clears stage valids and loads register defaults
module rgb_to_rgba16_converter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input beat channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  rgb2rgba16_pkg::t_in_beat          i_in_data,
    // output beat channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output rgb2rgba16_pkg::t_out_beat         o_out_data,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rgb2rgba16_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rgb2rgba16_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int NSTG = 5;

    // configuration registers
    logic [4:0] r_sample_bits;
    logic [2:0] r_format_flags;
    logic [3:0] r_invert_mask;
    logic [7:0] r_gain_red, r_gain_green, r_gain_blue, r_gain_alpha;

    // per-stage valid and advance
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] stg_rdy;

    logic [3:0]  shift_amt;
    logic        swap;
    logic [15:0] lane_red, lane_green, lane_blue, lane_alpha;
    logic [15:0] exp_red, exp_green, exp_blue;
    logic [15:0] r_alpha_d1, r_alpha_d2, r_alpha_d3;

    rgb2rgba16_pkg::t_lane_ctl lane_ctl;
    rgb2rgba16_pkg::t_exp_ctl  exp_ctl;

    // config port never backs up
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_bits  <= 5'd8;
            r_format_flags <= 3'd0;
            r_invert_mask  <= 4'd0;
            r_gain_red     <= 8'd1;
            r_gain_green   <= 8'd1;
            r_gain_blue    <= 8'd1;
            r_gain_alpha   <= 8'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rgb2rgba16_pkg::REG_SAMPLE_BITS:  r_sample_bits  <= i_cfg_data[4:0];
                rgb2rgba16_pkg::REG_FORMAT_FLAGS: r_format_flags <= i_cfg_data[2:0];
                rgb2rgba16_pkg::REG_INVERT_MASK:  r_invert_mask  <= i_cfg_data[3:0];
                rgb2rgba16_pkg::REG_GAIN_RED:     r_gain_red     <= i_cfg_data;
                rgb2rgba16_pkg::REG_GAIN_GREEN:   r_gain_green   <= i_cfg_data;
                rgb2rgba16_pkg::REG_GAIN_BLUE:    r_gain_blue    <= i_cfg_data;
                rgb2rgba16_pkg::REG_GAIN_ALPHA:   r_gain_alpha   <= i_cfg_data;
                default: ;  // index beyond the list is dropped
            endcase
        end
    end

    // a stage loads when it is empty or its content moves on
    always_comb begin
        stg_rdy[NSTG-1] = !r_vld[NSTG-1] || !i_out_stall;
        for (int k = NSTG-2; k >= 0; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_stall  = !stg_rdy[0];
    assign o_out_valid = r_vld[NSTG-1];

    // derived controls; the user must keep config static while beats are in flight, the block does not enforce it
    assign shift_amt = rgb2rgba16_pkg::depth_shift(r_sample_bits);
    assign swap      = r_format_flags[0] && (shift_amt != 4'd8);

    assign lane_ctl.en_mul  = stg_rdy[0];
    assign lane_ctl.en_clip = stg_rdy[1];
    assign exp_ctl.en_e1    = stg_rdy[2];
    assign exp_ctl.en_e2    = stg_rdy[3];
    assign exp_ctl.en_e3    = stg_rdy[4];

    // four component lanes side by side
    rgb2rgba16_lane u_lane_red (
        .i_clk    (i_clk),
        .i_ctl    (lane_ctl),
        .i_sample (i_in_data.sample_red),
        .i_swap   (swap),
        .i_gain   (r_gain_red),
        .i_shift  (shift_amt),
        .i_invert (r_invert_mask[0]),
        .o_value  (lane_red)
    );

    rgb2rgba16_lane u_lane_green (
        .i_clk    (i_clk),
        .i_ctl    (lane_ctl),
        .i_sample (i_in_data.sample_green),
        .i_swap   (swap),
        .i_gain   (r_gain_green),
        .i_shift  (shift_amt),
        .i_invert (r_invert_mask[1]),
        .o_value  (lane_green)
    );

    rgb2rgba16_lane u_lane_blue (
        .i_clk    (i_clk),
        .i_ctl    (lane_ctl),
        .i_sample (i_in_data.sample_blue),
        .i_swap   (swap),
        .i_gain   (r_gain_blue),
        .i_shift  (shift_amt),
        .i_invert (r_invert_mask[2]),
        .o_value  (lane_blue)
    );

    rgb2rgba16_lane u_lane_alpha (
        .i_clk    (i_clk),
        .i_ctl    (lane_ctl),
        .i_sample (i_in_data.sample_alpha),
        .i_swap   (swap),
        .i_gain   (r_gain_alpha),
        .i_shift  (shift_amt),
        .i_invert (r_invert_mask[3]),
        .o_value  (lane_alpha)
    );

    // range expansion on color lanes only
    rgb2rgba16_expand u_exp_red (
        .i_clk     (i_clk),
        .i_ctl     (exp_ctl),
        .i_limited (r_format_flags[2]),
        .i_value   (lane_red),
        .o_value   (exp_red)
    );

    rgb2rgba16_expand u_exp_green (
        .i_clk     (i_clk),
        .i_ctl     (exp_ctl),
        .i_limited (r_format_flags[2]),
        .i_value   (lane_green),
        .o_value   (exp_green)
    );

    rgb2rgba16_expand u_exp_blue (
        .i_clk     (i_clk),
        .i_ctl     (exp_ctl),
        .i_limited (r_format_flags[2]),
        .i_value   (lane_blue),
        .o_value   (exp_blue)
    );

    // alpha rides alongside the expanders, forced opaque when absent
    always_ff @(posedge i_clk) begin
        if (exp_ctl.en_e1) begin
            r_alpha_d1 <= r_format_flags[1] ? lane_alpha : rgb2rgba16_pkg::FULL_MAX;
        end
        if (exp_ctl.en_e2) begin
            r_alpha_d2 <= r_alpha_d1;
        end
        if (exp_ctl.en_e3) begin
            r_alpha_d3 <= r_alpha_d2;
        end
    end

    // merge lanes into the output beat
    always_comb begin
        o_out_data.out_red   = exp_red;
        o_out_data.out_green = exp_green;
        o_out_data.out_blue  = exp_blue;
        o_out_data.out_alpha = r_alpha_d3;
    end

endmodule
